>>> design/product_rule_cluster_merge_assert.svh
// Assertion macros for the product rule cluster merge block
`ifndef PRODUCT_RULE_CLUSTER_MERGE_ASSERT_SVH
`define PRODUCT_RULE_CLUSTER_MERGE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PRCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prcm assertion failed");

// antecedent implies consequent in the next cycle
`define PRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prcm assertion failed");

`endif

>>> design/prcm_pkg.sv
// Shared constants, types and codes for the product rule cluster merge block
package prcm_pkg;
    localparam int MAX_NODES      = 4096;
    localparam int NODE_W         = $clog2(MAX_NODES);
    localparam int SIZE_W         = 13;
    localparam int PROD_W         = 25;
    localparam int CUBE_W         = 37;
    localparam int MAX_CANDIDATES = 16;
    localparam int POS_W          = 4;
    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 112;

    typedef enum logic [4:0] {
        S_CLR_INIT, S_CLR, S_IDLE, S_DISPATCH, S_LINK_A, S_HOP_A, S_LINK_B, S_HOP_B,
        S_SZ_A, S_SZ_B, S_SZ_C, S_MUL, S_CMP, S_COUNT, S_MERGE, S_MOMENT,
        S_BIG_SQ, S_BIG_CU, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR_INIT, OP_CLR_STEP, OP_LOAD, OP_HOP_A, OP_HOP_B,
        OP_SZ_A, OP_SZ_B, OP_SZ_C, OP_MUL, OP_CMP, OP_COUNT, OP_MERGE,
        OP_MOMENT, OP_BIG_SQ, OP_BIG_CU, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic at_root;
        logic restart;
        logic eligible;
        logic last;
        logic out_free;
    } t_status;
endpackage

>>> design/prcm_ram.sv
// Generic single write port RAM with registered read
module prcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/prcm_ctrl.sv
// Sequencer for clearing, root walks, selection and merge
module prcm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic              i_accept,
    input  prcm_pkg::t_status i_status,
    output prcm_pkg::t_cmd    o_cmd,
    output logic              o_ready
);
    import prcm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_ready  = 1'b0;
        case (r_state)
            S_CLR_INIT: begin
                o_cmd.op = OP_CLR_INIT;
                n_state  = S_CLR;
            end
            S_CLR: begin
                o_cmd.op = OP_CLR_STEP;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.restart) n_state = S_CLR_INIT;
                else if (i_status.eligible) n_state = S_HOP_A;
                else n_state = S_COUNT;
            end
            S_LINK_A: n_state = S_HOP_A;
            S_HOP_A: begin
                o_cmd.op = OP_HOP_A;
                n_state  = i_status.at_root ? S_LINK_B : S_LINK_A;
            end
            S_LINK_B: n_state = S_HOP_B;
            S_HOP_B: begin
                o_cmd.op = OP_HOP_B;
                n_state  = i_status.at_root ? S_SZ_A : S_LINK_B;
            end
            S_SZ_A: begin
                o_cmd.op = OP_SZ_A;
                n_state  = S_SZ_B;
            end
            S_SZ_B: begin
                o_cmd.op = OP_SZ_B;
                n_state  = S_SZ_C;
            end
            S_SZ_C: begin
                o_cmd.op = OP_SZ_C;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.op = OP_COUNT;
                n_state  = i_status.last ? S_MERGE : S_IDLE;
            end
            S_MERGE: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_MOMENT;
            end
            S_MOMENT: begin
                o_cmd.op = OP_MOMENT;
                n_state  = S_BIG_SQ;
            end
            S_BIG_SQ: begin
                o_cmd.op = OP_BIG_SQ;
                n_state  = S_BIG_CU;
            end
            S_BIG_CU: begin
                o_cmd.op = OP_BIG_CU;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLR_INIT;
        endcase
        // a register write clears all clusters
        if (i_cfg_wen) n_state = S_CLR_INIT;
    end
endmodule

>>> design/prcm_datapath.sv
// Node memories, selection registers, moment arithmetic and output register
module prcm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prcm_pkg::t_cmd                      i_cmd,
    output prcm_pkg::t_status                   o_status,
    input  logic                                i_cfg_wen,
    input  logic [prcm_pkg::SIZE_W-1:0]         i_cfg_wdata,
    input  logic                                i_mode,
    input  logic [prcm_pkg::NODE_W-1:0]         i_node_a,
    input  logic [prcm_pkg::NODE_W-1:0]         i_node_b,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [prcm_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import prcm_pkg::*;

    localparam logic [SIZE_W-1:0] NodesMax = SIZE_W'(MAX_NODES);
    localparam logic [PROD_W-1:0] ProdMax  = {PROD_W{1'b1}};

    logic [SIZE_W-1:0] r_nc;
    logic [NODE_W-1:0] r_clr;
    logic              r_mode, r_last;
    logic [NODE_W-1:0] r_a, r_b, r_cur, r_ra, r_rb;
    logic [SIZE_W-1:0] r_sa, r_sb;
    logic [PROD_W-1:0] r_prod;
    logic              r_best_valid;
    logic [PROD_W-1:0] r_best_prod;
    logic [NODE_W-1:0] r_best_ra, r_best_rb;
    logic [SIZE_W-1:0] r_best_sa, r_best_sb;
    logic [POS_W-1:0]  r_best_pos, r_count;
    logic [SIZE_W-1:0] r_largest, r_ns;
    logic              r_merged;
    logic [PROD_W-1:0] r_sq;
    logic [CUBE_W-1:0] r_cu, r_cterm;
    logic [2*SIZE_W-1:0] r_bsq;
    logic [CUBE_W-1:0] r_bcu;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              link_we, size_we;
    logic [NODE_W-1:0] link_waddr, link_wdata, size_waddr, size_raddr, link_rdata;
    logic [SIZE_W-1:0] size_wdata, size_rdata, ns, big;
    logic              do_merge;
    logic [2*SIZE_W-1:0] sa_sb;
    logic [PROD_W+SIZE_W-1:0] prod_ns;
    logic [CUBE_W+2:0] bcu_full;
    logic [SIZE_W-1:0] cfg_sat;

    prcm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_link_ram (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(r_cur), .o_rdata(link_rdata)
    );

    prcm_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_NODES)) u_size_ram (
        .i_clk(i_clk), .i_we(size_we), .i_waddr(size_waddr), .i_wdata(size_wdata),
        .i_raddr(size_raddr), .o_rdata(size_rdata)
    );

    assign ns       = r_best_sa + r_best_sb;
    assign do_merge = r_best_valid && (r_best_ra != r_best_rb);
    assign big      = r_largest;
    assign sa_sb    = r_sa * r_sb;
    assign prod_ns  = r_best_prod * ns;
    assign bcu_full = r_bsq * big;
    assign size_raddr = (i_cmd.op == OP_SZ_A) ? r_ra : r_rb;

    always_comb begin
        if (i_cfg_wdata == '0) cfg_sat = SIZE_W'(1);
        else if (i_cfg_wdata > NodesMax) cfg_sat = NodesMax;
        else cfg_sat = i_cfg_wdata;
    end

    always_comb begin
        link_we    = 1'b0;
        size_we    = 1'b0;
        link_waddr = r_clr;
        link_wdata = r_clr;
        size_waddr = r_clr;
        size_wdata = SIZE_W'(1);
        if (i_cmd.op == OP_CLR_STEP) begin
            link_we = 1'b1;
            size_we = 1'b1;
        end else if (i_cmd.op == OP_MERGE && do_merge) begin
            link_we    = 1'b1;
            size_we    = 1'b1;
            size_wdata = ns;
            // larger cluster keeps its root, node A's side on equal sizes
            if (r_best_sa >= r_best_sb) begin
                size_waddr = r_best_ra;
                link_waddr = r_best_rb;
                link_wdata = r_best_ra;
            end else begin
                size_waddr = r_best_rb;
                link_waddr = r_best_ra;
                link_wdata = r_best_rb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc        <= NodesMax;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) r_nc <= cfg_sat;
            if (i_cmd.op == OP_EMIT) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CLR_INIT: begin
                r_clr        <= '0;
                r_largest    <= SIZE_W'(1);
                r_sq         <= PROD_W'(r_nc);
                r_cu         <= CUBE_W'(r_nc);
                r_best_valid <= 1'b0;
                r_best_prod  <= ProdMax;
                r_count      <= '0;
            end
            OP_CLR_STEP: r_clr <= r_clr + 1'b1;
            OP_LOAD: begin
                r_mode <= i_mode;
                r_last <= i_last;
                r_a    <= i_node_a;
                r_b    <= i_node_b;
                r_cur  <= i_node_a;
            end
            OP_HOP_A: begin
                if (link_rdata == r_cur) begin
                    r_ra  <= r_cur;
                    r_cur <= r_b;
                end else begin
                    r_cur <= link_rdata;
                end
            end
            OP_HOP_B: begin
                if (link_rdata == r_cur) r_rb <= r_cur;
                else r_cur <= link_rdata;
            end
            OP_SZ_B: r_sa <= size_rdata;
            OP_SZ_C: r_sb <= size_rdata;
            OP_MUL:  r_prod <= sa_sb[PROD_W-1:0];
            OP_CMP: begin
                // strict compare keeps the earliest on a tie
                if (!r_best_valid || r_prod < r_best_prod) begin
                    r_best_valid <= 1'b1;
                    r_best_prod  <= r_prod;
                    r_best_ra    <= r_ra;
                    r_best_rb    <= r_rb;
                    r_best_sa    <= r_sa;
                    r_best_sb    <= r_sb;
                    r_best_pos   <= r_count;
                end
            end
            OP_COUNT: begin
                if (r_count != POS_W'(MAX_CANDIDATES - 1)) r_count <= r_count + 1'b1;
            end
            OP_MERGE: begin
                r_merged <= do_merge;
                r_ns     <= do_merge ? ns : '0;
                r_cterm  <= prod_ns[CUBE_W-1:0];
                if (do_merge) begin
                    r_sq <= r_sq + {r_best_prod[PROD_W-2:0], 1'b0};
                    if (ns > r_largest) r_largest <= ns;
                end
            end
            OP_MOMENT: begin
                if (r_merged) r_cu <= r_cu + r_cterm + {r_cterm[CUBE_W-2:0], 1'b0};
            end
            OP_BIG_SQ: r_bsq <= big * big;
            OP_BIG_CU: r_bcu <= bcu_full[CUBE_W-1:0];
            OP_EMIT: begin
                r_out_data <= {
                    {(OUT_DATA_W - 106){1'b0}},
                    r_cu - r_bcu,
                    r_sq - r_bsq[PROD_W-1:0],
                    r_nc - big,
                    big,
                    r_ns,
                    r_merged,
                    r_best_valid ? r_best_pos : {POS_W{1'b0}}
                };
                r_best_valid <= 1'b0;
                r_best_prod  <= ProdMax;
                r_count      <= '0;
            end
            default: ;
        endcase
    end

    assign o_status.clr_done = (r_clr == NODE_W'(MAX_NODES - 1));
    assign o_status.at_root  = (link_rdata == r_cur);
    assign o_status.restart  = r_mode;
    assign o_status.eligible = ({1'b0, r_a} < r_nc) && ({1'b0, r_b} < r_nc);
    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

>>> design/product_rule_cluster_merge.sv
// Top level of the product rule cluster merge block
//  channel   | direction | signals                         | payload
//  s_axis    | in        | tvalid tready tdata tuser tlast | node_a, node_b; mode; last
//  m_axis    | out       | tvalid tready tdata             | results of a closed group
//  cfg       | in        | cfg_wen cfg_wdata               | node_count
// An in-range candidate holds off the input after its transfer while it walks both
// root paths, a parent hop at a time (one link memory port); a closing candidate
// also merges and updates the moments. An out-of-range candidate skips the root walks.
// Reset, a restart item and a register write run a clearing pass over both node
// memories; no transfer is taken meanwhile.
// A stalled result stays in the output register; the next closing candidate waits on it.
module product_rule_cluster_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [prcm_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [11:0] node_a, [23:12] node_b
    input  logic [prcm_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] mode
    input  logic                              i_s_tuser,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] chosen_position, [4] merged, [17:5] join size, [30:18] largest_size,
    // [43:31] sum_sizes, [68:44] sum_squares, [105:69] sum_cubes, rest zero
    output logic [prcm_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import prcm_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    accept;

    assign accept = i_s_tvalid && o_s_tready;

    prcm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wen(i_cfg_wen), .i_accept(accept),
        .i_status(status), .o_cmd(cmd), .o_ready(o_s_tready)
    );

    prcm_datapath u_datapath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_mode(i_s_tuser), .i_node_a(i_s_tdata[NODE_W-1:0]),
        .i_node_b(i_s_tdata[2*NODE_W-1:NODE_W]), .i_last(i_s_tlast),
        .o_out_valid(o_m_tvalid), .i_out_ready(i_m_tready), .o_out_data(o_m_tdata)
    );

`include "product_rule_cluster_merge_assert.svh"

    `PRCM_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, accept, !o_s_tready)
    `PRCM_ASSERT_NOW(a_emit_when_free, i_clk, i_rst_n, cmd.op == OP_EMIT, status.out_free)
    `PRCM_ASSERT_NOW(a_size_iff_merged, i_clk, i_rst_n, o_m_tvalid,
                     o_m_tdata[4] == (o_m_tdata[17:5] != 13'd0))
endmodule
